// ===== hdl/abump_pkg.sv =====
`timescale 1ns / 1ps

package abump_pkg;

    localparam int OFFSET_W = 21;
    localparam int ID_W     = 16;
    localparam int ALIGN_W  = 4;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int CALC_W   = 23;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC    = 3'd0,
        REQ_REALLOC  = 3'd1,
        REQ_FREE     = 3'd2,
        REQ_SAVE     = 3'd3,
        REQ_RESTORE  = 3'd4,
        REQ_FREE_ALL = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BOUNDS   = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic                has_block;
        logic [OFFSET_W-1:0] block_offset;
        logic [OFFSET_W-1:0] cur_size;
        logic [OFFSET_W-1:0] req_size;
        logic [ALIGN_W-1:0]  align_log2;
        logic [OFFSET_W-1:0] mark_used;
        logic [ID_W-1:0]     mark_id;
    } t_req_item;

    typedef struct packed {
        t_status             status;
        logic [OFFSET_W-1:0] result_offset;
        logic [ID_W-1:0]     result_id;
        logic                moved;
        logic [OFFSET_W-1:0] clear_offset;
        logic [OFFSET_W-1:0] clear_length;
        logic [OFFSET_W-1:0] used_after;
    } t_rsp_item;

    // width of the used-bytes counter for a given offset range
    function automatic int f_used_w(input int offset_bits);
        return (offset_bits + 1 < OFFSET_W) ? offset_bits + 1 : OFFSET_W;
    endfunction

endpackage

// ===== hdl/abump_exec.sv =====
`timescale 1ns / 1ps

module abump_exec #(
    parameter int OFFSET_BITS    = 20,
    parameter int ID_BITS        = 16,
    parameter int MAX_ALIGN_LOG2 = 12,
    localparam int UsedW         = abump_pkg::f_used_w(OFFSET_BITS)
) (
    input  abump_pkg::t_req_item                   i_req,
    input  logic [abump_pkg::OFFSET_W-1:0]         i_capacity,
    input  logic [UsedW-1:0]                       i_used,
    input  logic [ID_BITS-1:0]                     i_depth,
    output logic [UsedW-1:0]                       o_used,
    output logic [ID_BITS-1:0]                     o_depth,
    output abump_pkg::t_rsp_item                   o_rsp
);

    localparam int CW = abump_pkg::CALC_W;
    localparam int IW = (ID_BITS > abump_pkg::ID_W) ? ID_BITS : abump_pkg::ID_W;
    localparam int OW = abump_pkg::OFFSET_W;
    localparam logic [CW-1:0] CapLim = (OFFSET_BITS >= OW) ?
                                       CW'({OW{1'b1}}) : CW'(64'd1 << OFFSET_BITS);

    logic [CW-1:0]      cap_raw, cap, a_m1, used_x, al_off, new_end;
    logic [CW-1:0]      blk, osz, nsz, mused, blk_end, blk_new_end;
    logic [4:0]         lg_sat;
    logic               fit, blk_oob, blk_last, inplace_fit, take_alloc, alloc_moved;
    logic [ID_BITS-1:0] dep_inc;

    always_comb begin
        cap_raw     = CW'(i_capacity);
        cap         = (cap_raw > CapLim) ? CapLim : cap_raw;
        lg_sat      = ({1'b0, i_req.align_log2} > 5'(MAX_ALIGN_LOG2)) ?
                      5'(MAX_ALIGN_LOG2) : {1'b0, i_req.align_log2};
        a_m1        = (CW'(1) << lg_sat) - CW'(1);
        used_x      = CW'(i_used);
        al_off      = (used_x + a_m1) & ~a_m1;
        blk         = CW'(i_req.block_offset);
        osz         = CW'(i_req.cur_size);
        nsz         = CW'(i_req.req_size);
        mused       = CW'(i_req.mark_used);
        new_end     = al_off + nsz;
        fit         = (al_off <= cap) && (new_end <= cap);
        blk_end     = blk + osz;
        blk_new_end = blk + nsz;
        blk_oob     = blk > cap;
        blk_last    = blk_end == used_x;
        inplace_fit = blk_new_end <= cap;
        dep_inc     = i_depth + ID_BITS'(1);

        take_alloc  = 1'b0;
        alloc_moved = 1'b0;
        o_used      = i_used;
        o_depth     = i_depth;
        o_rsp       = '0;
        o_rsp.status = abump_pkg::ST_OK;

        unique case (i_req.req_type)
            abump_pkg::REQ_ALLOC: begin
                take_alloc = 1'b1;
            end
            abump_pkg::REQ_REALLOC: begin
                if (!i_req.has_block) begin
                    take_alloc = 1'b1;
                end else if (blk_oob) begin
                    o_rsp.status = abump_pkg::ST_BOUNDS;
                end else if (blk_last && inplace_fit) begin
                    o_used              = UsedW'(blk_new_end);
                    o_rsp.result_offset = OW'(blk);
                    if (nsz > osz) begin
                        o_rsp.clear_offset = OW'(blk_end);
                        o_rsp.clear_length = OW'(nsz - osz);
                    end
                end else begin
                    take_alloc  = 1'b1;
                    alloc_moved = 1'b1;
                end
            end
            abump_pkg::REQ_FREE: begin
                if (i_req.has_block) begin
                    if (blk_oob) begin
                        o_rsp.status = abump_pkg::ST_BOUNDS;
                    end else if (blk_last) begin
                        o_used = UsedW'(blk);
                    end
                end
            end
            abump_pkg::REQ_SAVE: begin
                if (i_depth == '1) begin
                    o_rsp.status = abump_pkg::ST_INVALID;
                end else begin
                    o_depth             = dep_inc;
                    o_rsp.result_offset = OW'(used_x);
                    o_rsp.result_id     = abump_pkg::ID_W'(dep_inc);
                end
            end
            abump_pkg::REQ_RESTORE: begin
                if (i_depth == '0 || IW'(i_req.mark_id) != IW'(i_depth)
                        || mused > used_x) begin
                    o_rsp.status = abump_pkg::ST_INVALID;
                end else begin
                    o_used  = UsedW'(mused);
                    o_depth = i_depth - ID_BITS'(1);
                end
            end
            abump_pkg::REQ_FREE_ALL: begin
                o_used = '0;
            end
            default: begin
            end
        endcase

        if (take_alloc) begin
            if (fit) begin
                o_used              = UsedW'(new_end);
                o_rsp.result_offset = OW'(al_off);
                o_rsp.clear_offset  = OW'(al_off);
                o_rsp.clear_length  = i_req.req_size;
                o_rsp.moved         = alloc_moved;
            end else begin
                o_rsp.status = abump_pkg::ST_NO_SPACE;
            end
        end

        o_rsp.used_after = OW'(o_used);
    end

endmodule

// ===== hdl/arena_bump_allocator.sv =====
`timescale 1ns / 1ps

// Channel     Dir  Handshake                  Payload
// s_axis      in   tvalid/tready              tdata: request fields, tuser: kind and block flag
// m_axis      out  tvalid/tready              tdata: result fields, tuser: status
// cfg         in   wr_en (no wait)            wr_data: capacity
//
// One item per cycle sustained while m_axis is ready; each item passes the request and result registers.
// The request register feeds one pass of add/mask/compare into the result register.
// Reset clears used bytes, save depth, capacity and both valid flags.
// A stalled result holds its register; one further item waits in the request register.

module arena_bump_allocator #(
    parameter int OFFSET_BITS    = 20,
    parameter int ID_BITS        = 16,
    parameter int MAX_ALIGN_LOG2 = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // block_offset, cur_size, req_size, align_log2, mark_used, mark_id
    input  logic [103:0]  i_s_axis_tdata,
    // req_type, has_block
    input  logic [3:0]    i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // result_offset, result_id, moved, clear_offset, clear_length, used_after, zero pad
    output logic [103:0]  o_m_axis_tdata,
    // status
    output logic [1:0]    o_m_axis_tuser,
    input  logic          i_cfg_wr_en,
    input  logic [20:0]   i_cfg_wr_data
);

    localparam int UsedW = abump_pkg::f_used_w(OFFSET_BITS);

    abump_pkg::t_req_item                  r_req, n_req;
    abump_pkg::t_rsp_item                  r_rsp, n_rsp;
    logic                                  r_req_valid, r_rsp_valid;
    logic [UsedW-1:0]                      r_used, n_used;
    logic [ID_BITS-1:0]                    r_depth, n_depth;
    logic [abump_pkg::OFFSET_W-1:0]        r_capacity;
    logic                                  advance, in_take;

    assign advance         = r_req_valid && (!r_rsp_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_req_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_req.req_type     = i_s_axis_tuser[2:0];
        n_req.has_block    = i_s_axis_tuser[3];
        n_req.block_offset = i_s_axis_tdata[20:0];
        n_req.cur_size     = i_s_axis_tdata[41:21];
        n_req.req_size     = i_s_axis_tdata[62:42];
        n_req.align_log2   = i_s_axis_tdata[66:63];
        n_req.mark_used    = i_s_axis_tdata[87:67];
        n_req.mark_id      = i_s_axis_tdata[103:88];
    end

    abump_exec #(
        .OFFSET_BITS    (OFFSET_BITS),
        .ID_BITS        (ID_BITS),
        .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
    ) u_exec (
        .i_req      (r_req),
        .i_capacity (r_capacity),
        .i_used     (r_used),
        .i_depth    (r_depth),
        .o_used     (n_used),
        .o_depth    (n_depth),
        .o_rsp      (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_used      <= '0;
            r_depth     <= '0;
            r_capacity  <= '0;
        end else begin
            if (in_take) begin
                r_req_valid <= 1'b1;
            end else if (advance) begin
                r_req_valid <= 1'b0;
            end
            if (advance) begin
                r_rsp_valid <= 1'b1;
                r_used      <= n_used;
                r_depth     <= n_depth;
            end else if (i_m_axis_tready) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req <= n_req;
        end
        if (advance) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_m_axis_tvalid = r_rsp_valid;
    assign o_m_axis_tuser  = r_rsp.status;
    assign o_m_axis_tdata  = {3'b000, r_rsp.used_after, r_rsp.clear_length,
                              r_rsp.clear_offset, r_rsp.moved, r_rsp.result_id,
                              r_rsp.result_offset};

endmodule

// ===== tb/arena_bump_allocator_tb.sv =====
`timescale 1ns / 1ps

module arena_bump_allocator_tb;

    localparam int unsigned CAP_LIMIT   = 1 << 20;
    localparam int unsigned DEPTH_LIMIT = (1 << 16) - 1;
    localparam int unsigned ALIGN_MAX   = 12;
    localparam int unsigned FIELD_MAX   = (1 << 21) - 1;
    localparam int unsigned ID_MAX      = (1 << 16) - 1;
    localparam int          IDLE_LIMIT  = 4000;
    localparam int          OW          = abump_pkg::OFFSET_W;
    localparam int          IW          = abump_pkg::ID_W;

    typedef enum int {RX_OPEN, RX_BUSY, RX_SLOW} t_rx_mode;

    typedef struct {
        int unsigned off;
        int unsigned len;
    } t_span;

    logic         i_clk           = 1'b0;
    logic         i_rst_n         = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic [103:0] i_s_axis_tdata  = '0;
    logic [3:0]   i_s_axis_tuser  = '0;
    logic         i_m_axis_tready = 1'b1;
    logic         i_cfg_wr_en     = 1'b0;
    logic [20:0]  i_cfg_wr_data   = '0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [103:0] o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;

    int unsigned arena_cap   = 0;
    int unsigned arena_used  = 0;
    int unsigned arena_depth = 0;

    abump_pkg::t_rsp_item outcome_q[$];
    abump_pkg::t_rsp_item due_r;
    t_span                span_q[$];
    int unsigned          mark_q[$];

    int       errors      = 0;
    int       idle_cycles = 0;
    int       burst_left  = 4;
    t_rx_mode rx_mode     = RX_OPEN;
    int       rx_left     = 20;

    arena_bump_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned eff_cap;
        return (arena_cap > CAP_LIMIT) ? CAP_LIMIT : arena_cap;
    endfunction

    function automatic bit try_place(input int unsigned size, input int unsigned lg,
                                     output int unsigned off);
        int unsigned cap_e;
        int unsigned a;
        int unsigned o;
        cap_e = eff_cap();
        off = 0;
        if (lg > ALIGN_MAX) lg = ALIGN_MAX;
        a = 1 << lg;
        o = (arena_used + a - 1) & ~(a - 1);
        if (o > cap_e || cap_e - o < size) return 1'b0;
        arena_used = o + size;
        off = o;
        return 1'b1;
    endfunction

    function automatic abump_pkg::t_rsp_item apply_request(input abump_pkg::t_req_item rq);
        abump_pkg::t_rsp_item r;
        int unsigned          cap_e;
        int unsigned          blk;
        int unsigned          osz;
        int unsigned          nsz;
        int unsigned          o;
        r = '0;
        cap_e = eff_cap();
        blk = 32'(rq.block_offset);
        osz = 32'(rq.cur_size);
        nsz = 32'(rq.req_size);
        if (rq.req_type == abump_pkg::REQ_ALLOC
                || (rq.req_type == abump_pkg::REQ_REALLOC && !rq.has_block)) begin
            if (try_place(nsz, 32'(rq.align_log2), o)) begin
                r.result_offset = OW'(o);
                r.clear_offset  = OW'(o);
                r.clear_length  = OW'(nsz);
            end else begin
                r.status = abump_pkg::ST_NO_SPACE;
            end
        end else if (rq.req_type == abump_pkg::REQ_REALLOC) begin
            if (blk > cap_e) begin
                r.status = abump_pkg::ST_BOUNDS;
            end else if (blk + osz == arena_used && blk + nsz <= cap_e) begin
                arena_used = blk + nsz;
                r.result_offset = OW'(blk);
                if (nsz > osz) begin
                    r.clear_offset = OW'(blk + osz);
                    r.clear_length = OW'(nsz - osz);
                end
            end else if (try_place(nsz, 32'(rq.align_log2), o)) begin
                r.result_offset = OW'(o);
                r.clear_offset  = OW'(o);
                r.clear_length  = OW'(nsz);
                r.moved         = 1'b1;
            end else begin
                r.status = abump_pkg::ST_NO_SPACE;
            end
        end else if (rq.req_type == abump_pkg::REQ_FREE) begin
            if (rq.has_block) begin
                if (blk > cap_e) r.status = abump_pkg::ST_BOUNDS;
                else if (blk + osz == arena_used) arena_used = blk;
            end
        end else if (rq.req_type == abump_pkg::REQ_SAVE) begin
            if (arena_depth >= DEPTH_LIMIT) begin
                r.status = abump_pkg::ST_INVALID;
            end else begin
                arena_depth = arena_depth + 1;
                r.result_offset = OW'(arena_used);
                r.result_id = IW'(arena_depth);
            end
        end else if (rq.req_type == abump_pkg::REQ_RESTORE) begin
            if (arena_depth == 0 || 32'(rq.mark_id) != arena_depth
                    || 32'(rq.mark_used) > arena_used) begin
                r.status = abump_pkg::ST_INVALID;
            end else begin
                arena_used = 32'(rq.mark_used);
                arena_depth = arena_depth - 1;
            end
        end else if (rq.req_type == abump_pkg::REQ_FREE_ALL) begin
            arena_used = 0;
        end
        r.used_after = OW'(arena_used);
        return r;
    endfunction

    task automatic send_item(input logic [2:0] kind, input logic has, input int unsigned blk,
                             input int unsigned osz, input int unsigned nsz,
                             input int unsigned lg, input int unsigned mused,
                             input int unsigned mid);
        abump_pkg::t_req_item rq;
        abump_pkg::t_rsp_item rs;
        rq.req_type     = kind;
        rq.has_block    = has;
        rq.block_offset = OW'(blk);
        rq.cur_size     = OW'(osz);
        rq.req_size     = OW'(nsz);
        rq.align_log2   = 4'(lg);
        rq.mark_used    = OW'(mused);
        rq.mark_id      = IW'(mid);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {rq.mark_id, rq.mark_used, rq.align_log2, rq.req_size,
                            rq.cur_size, rq.block_offset};
        i_s_axis_tuser  <= {rq.has_block, rq.req_type};
        do @(posedge i_clk); while (!o_s_axis_tready);
        rs = apply_request(rq);
        outcome_q.push_back(rs);
        if (rs.status == abump_pkg::ST_OK) begin
            case (rq.req_type)
                abump_pkg::REQ_ALLOC:
                    span_q.push_back('{off: 32'(rs.result_offset), len: 32'(rq.req_size)});
                abump_pkg::REQ_REALLOC: begin
                    if (rq.has_block && !rs.moved) begin
                        while (span_q.size() != 0 && span_q[$].off >= 32'(rq.block_offset))
                            void'(span_q.pop_back());
                    end
                    span_q.push_back('{off: 32'(rs.result_offset), len: 32'(rq.req_size)});
                end
                abump_pkg::REQ_SAVE: mark_q.push_back(32'(rs.result_offset));
                abump_pkg::REQ_RESTORE: if (mark_q.size() != 0) void'(mark_q.pop_back());
                default: ;
            endcase
            while (span_q.size() != 0 && span_q[$].off + span_q[$].len > arena_used)
                void'(span_q.pop_back());
        end
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input int unsigned value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[20:0];
        @(posedge i_clk);
        arena_cap = value & FIELD_MAX;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h/%h", $time,
                         o_m_axis_tuser, o_m_axis_tdata);
                errors++;
            end else begin
                due_r = outcome_q.pop_front();
                check_field("status", due_r.status, o_m_axis_tuser);
                check_field("result_offset", due_r.result_offset, o_m_axis_tdata[20:0]);
                check_field("result_id", due_r.result_id, o_m_axis_tdata[36:21]);
                check_field("moved", due_r.moved, o_m_axis_tdata[37]);
                check_field("clear_offset", due_r.clear_offset, o_m_axis_tdata[58:38]);
                check_field("clear_length", due_r.clear_length, o_m_axis_tdata[79:59]);
                check_field("used_after", due_r.used_after, o_m_axis_tdata[100:80]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_left <= $urandom_range(8, 64);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN: i_m_axis_tready <= 1'b1;
            RX_BUSY: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: i_m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned pick_size;
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 8) return $urandom_range(0, 256);
        if (roll == 8) return $urandom_range(0, CAP_LIMIT);
        return $urandom_range(0, FIELD_MAX);
    endfunction

    function automatic int unsigned pick_align;
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
    endfunction

    task automatic random_request;
        logic [2:0]  kind;
        logic        has;
        int unsigned blk;
        int unsigned osz;
        int unsigned nsz;
        int unsigned lg;
        int unsigned mused;
        int unsigned mid;
        int unsigned pick;
        int unsigned sel;
        t_span       sp;
        kind  = 3'($urandom_range(0, 7));
        has   = 1'($urandom_range(0, 1));
        blk   = $urandom_range(0, FIELD_MAX);
        osz   = $urandom_range(0, FIELD_MAX);
        nsz   = $urandom_range(0, FIELD_MAX);
        lg    = $urandom_range(0, 15);
        mused = $urandom_range(0, FIELD_MAX);
        mid   = $urandom_range(0, ID_MAX);
        pick  = $urandom_range(0, 99);
        sel   = $urandom_range(0, 9);
        if (pick < 65 && pick >= 30 && span_q.size() != 0 && sel < 9) begin
            if (sel < 7) begin
                sp = span_q[$];
            end else begin
                sp = span_q[$urandom_range(0, span_q.size() - 1)];
            end
            has = 1'b1;
            blk = sp.off;
            osz = sp.len;
        end
        if (pick < 30) begin
            kind = abump_pkg::REQ_ALLOC;
            nsz  = pick_size();
            lg   = pick_align();
        end else if (pick < 50) begin
            kind = abump_pkg::REQ_REALLOC;
            nsz  = pick_size();
            lg   = pick_align();
            if (has && blk <= eff_cap() && $urandom_range(0, 7) == 0) nsz = eff_cap() - blk;
        end else if (pick < 65) begin
            kind = abump_pkg::REQ_FREE;
        end else if (pick < 75) begin
            kind = abump_pkg::REQ_SAVE;
        end else if (pick < 87) begin
            kind = abump_pkg::REQ_RESTORE;
            if (sel < 8) begin
                mid = arena_depth;
                mused = (mark_q.size() != 0) ? mark_q[$] : $urandom_range(0, arena_used);
            end
        end else if (pick < 91) begin
            kind = abump_pkg::REQ_FREE_ALL;
        end else if (pick < 94) begin
            kind = 3'(abump_pkg::REQ_FREE_ALL + $urandom_range(1, 2));
        end
        send_item(kind, has, blk, osz, nsz, lg, mused, mid);
    endtask

    task automatic test_alloc_alignment;
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, 0, 0, 0, 0);
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, 1, 0, 0, 0);
        write_capacity(1000);
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, 10, 0, 0, 0);
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, 5, 3, 0, 0);
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, 3, 0, 0, 0);
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, 4, 3, 0, 0);
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, 0, 15, 0, 0);
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, FIELD_MAX, 0, 0, 0);
    endtask

    task automatic test_realloc_paths;
        send_item(abump_pkg::REQ_REALLOC, 1'b1, 24, 4, 976, 0, 0, 0);
        send_item(abump_pkg::REQ_REALLOC, 1'b1, 24, 976, 100, 0, 0, 0);
        send_item(abump_pkg::REQ_REALLOC, 1'b1, 0, 10, 20, 2, 0, 0);
        send_item(abump_pkg::REQ_REALLOC, 1'b1, 0, 10, 2000, 0, 0, 0);
        send_item(abump_pkg::REQ_REALLOC, 1'b0, 0, 0, 6, 0, 0, 0);
        send_item(abump_pkg::REQ_REALLOC, 1'b1, FIELD_MAX, 0, 8, 0, 0, 0);
    endtask

    task automatic test_free_paths;
        send_item(abump_pkg::REQ_FREE, 1'b1, 144, 6, 0, 0, 0, 0);
        send_item(abump_pkg::REQ_FREE, 1'b1, 0, 10, 0, 0, 0, 0);
        send_item(abump_pkg::REQ_FREE, 1'b0, 0, 0, 0, 0, 0, 0);
        send_item(abump_pkg::REQ_FREE, 1'b1, 1048577, 0, 0, 0, 0, 0);
    endtask

    task automatic test_mark_nesting;
        send_item(abump_pkg::REQ_SAVE, 1'b0, 0, 0, 0, 0, 0, 0);
        send_item(abump_pkg::REQ_SAVE, 1'b0, 0, 0, 0, 0, 0, 0);
        send_item(abump_pkg::REQ_RESTORE, 1'b0, 0, 0, 0, 0, 0, 1);
        send_item(abump_pkg::REQ_RESTORE, 1'b0, 0, 0, 0, 0, FIELD_MAX, 2);
        send_item(abump_pkg::REQ_RESTORE, 1'b0, 0, 0, 0, 0, 100, 2);
        send_item(abump_pkg::REQ_RESTORE, 1'b0, 0, 0, 0, 0, 0, 1);
        send_item(abump_pkg::REQ_RESTORE, 1'b0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_free_all_and_unused;
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, 40, 0, 0, 0);
        send_item(abump_pkg::REQ_FREE_ALL, 1'b0, 0, 0, 0, 0, 0, 0);
        send_item(3'(abump_pkg::REQ_FREE_ALL + 1), 1'b1, 5, 5, 5, 5, 5, 5);
        send_item(3'(abump_pkg::REQ_FREE_ALL + 2), 1'b1, FIELD_MAX, FIELD_MAX, FIELD_MAX, 15,
                  FIELD_MAX, ID_MAX);
    endtask

    task automatic test_capacity_below_use;
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, 50, 0, 0, 0);
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, 400, 0, 0, 0);
        write_capacity(100);
        send_item(abump_pkg::REQ_ALLOC, 1'b0, 0, 0, 1, 0, 0, 0);
        send_item(abump_pkg::REQ_FREE, 1'b1, 50, 400, 0, 0, 0, 0);
    endtask

    task automatic test_random_traffic;
        int unsigned caps[6];
        int          counts[6];
        caps   = '{4096, CAP_LIMIT, FIELD_MAX, 600, 0, 0};
        counts = '{80, 90, 75, 75, 67, 30};
        caps[4] = $urandom_range(0, FIELD_MAX);
        for (int p = 0; p < 6; p++) begin
            write_capacity(caps[p]);
            repeat (counts[p]) random_request();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_alloc_alignment();
        test_realloc_paths();
        test_free_paths();
        test_mark_nesting();
        test_free_all_and_unused();
        test_capacity_below_use();
        test_random_traffic();
        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
